// ===== rtl/pmeq_pkg.sv =====
// Shared types and constants of the path maximum edge query block.
package pmeq_pkg;

    localparam int NODES_DEF       = 64;
    localparam int WEIGHT_BITS_DEF = 31;
    localparam int NODE_FIELD_W    = 6;
    localparam int WEIGHT_FIELD_W  = 31;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [NODE_FIELD_W-1:0]   node_a;
        logic [NODE_FIELD_W-1:0]   node_b;
        logic [WEIGHT_FIELD_W-1:0] weight;
    } in_t;

    typedef struct packed {
        logic [WEIGHT_FIELD_W-1:0] max_weight;
        logic                      found;
    } out_t;

endpackage

// ===== rtl/pmeq_adj_ram.sv =====
// Single-port-write, single-port-read adjacency RAM with registered read data.
module pmeq_adj_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 31
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/path_max_edge_query.sv =====
// Top level of the path maximum edge query block: edge store and depth-first search.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------------
//   in      | into      | in_valid/in_stall  | pmeq_pkg::in_t  (func, nodes, weight)
//   out     | out of    | out_valid/out_stall| pmeq_pkg::out_t (max_weight, found)
//
// After reset the adjacency RAM is cleared one entry per cycle, all 2**(2*clog2(NODES))
// entries (4096 at the default size); in_stall stays high meanwhile.
// An edge load makes both symmetric RAM writes, one in ST_IDLE and one in ST_WR2.
// A query scans neighbors one by one through the single adjacency read port, pushing a
// frame on each descent and popping it through ST_POP when a node's row is done.
// A finished result sits in the output register; a stalled output holds the next
// query's result in the response state until the register frees up.
module path_max_edge_query #(
    parameter int NODES       = pmeq_pkg::NODES_DEF,
    parameter int WEIGHT_BITS = pmeq_pkg::WEIGHT_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pmeq_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output pmeq_pkg::out_t out_data
);

    localparam int IDX_W  = $clog2(NODES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADJ_AW = 2 * IDX_W;
    localparam int STK_W  = IDX_W + CNT_W + WEIGHT_BITS;

    // One-hot controller states.
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WR2   = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_POP   = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADJ_AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]        dst_reg, dst_next;
    logic [IDX_W-1:0]        cur_node_reg, cur_node_next;
    logic [WEIGHT_BITS-1:0]  cur_best_reg, cur_best_next;
    logic [CNT_W-1:0]        scan_i_reg, scan_i_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]        sp_reg, sp_next;
    logic [NODES-1:0]        visited_reg, visited_next;
    logic                    res_found_reg, res_found_next;
    logic [WEIGHT_BITS-1:0]  res_best_reg, res_best_next;
    logic [IDX_W-1:0]        ld_row_reg, ld_row_next;
    logic [IDX_W-1:0]        ld_col_reg, ld_col_next;
    logic [WEIGHT_BITS-1:0]  ld_w_reg, ld_w_next;
    logic                    out_vld_reg, out_vld_next;
    pmeq_pkg::out_t          out_data_reg, out_data_next;

    logic                    adj_we;
    logic [ADJ_AW-1:0]       adj_waddr;
    logic [WEIGHT_BITS-1:0]  adj_wdata;
    logic [ADJ_AW-1:0]       adj_raddr;
    logic [WEIGHT_BITS-1:0]  adj_rdata;

    // The stack keeps the parent frames; the frame being scanned lives in registers.
    logic [STK_W-1:0]        stk_mem [0:NODES-1];
    logic                    stk_we;
    logic [IDX_W-1:0]        stk_waddr;
    logic [STK_W-1:0]        stk_wdata;
    logic [IDX_W-1:0]        stk_raddr;
    logic [STK_W-1:0]        stk_rdata_reg;

    logic                    a_ok, b_ok;
    logic [IDX_W-1:0]        a_idx, b_idx;
    logic [WEIGHT_BITS-1:0]  w_in;
    logic                    scan_end;
    logic                    hit;
    logic [WEIGHT_BITS-1:0]  cand;
    logic [IDX_W-1:0]        scan_idx;

    pmeq_adj_ram #(
        .ADDR_W (ADJ_AW),
        .DATA_W (WEIGHT_BITS)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    assign a_ok  = (32'(in_data.node_a) < 32'(NODES));
    assign b_ok  = (32'(in_data.node_b) < 32'(NODES));
    assign a_idx = IDX_W'(in_data.node_a);
    assign b_idx = IDX_W'(in_data.node_b);
    assign w_in  = WEIGHT_BITS'(in_data.weight);

    assign scan_idx  = scan_i_reg[IDX_W-1:0];
    assign scan_end  = (scan_i_reg == CNT_W'(NODES));
    // The read data belongs to the neighbor issued in the previous cycle.
    assign hit       = pend_vld_reg && (adj_rdata != '0);
    assign cand      = (adj_rdata > cur_best_reg) ? adj_rdata : cur_best_reg;
    assign adj_raddr = {cur_node_reg, scan_idx};
    assign stk_raddr = IDX_W'(sp_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        dst_next       = dst_reg;
        cur_node_next  = cur_node_reg;
        cur_best_next  = cur_best_reg;
        scan_i_next    = scan_i_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        sp_next        = sp_reg;
        visited_next   = visited_reg;
        res_found_next = res_found_reg;
        res_best_next  = res_best_reg;
        ld_row_next    = ld_row_reg;
        ld_col_next    = ld_col_reg;
        ld_w_next      = ld_w_reg;
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        adj_we         = 1'b0;
        adj_waddr      = {ld_row_reg, ld_col_reg};
        adj_wdata      = ld_w_reg;
        stk_we         = 1'b0;
        stk_waddr      = sp_reg[IDX_W-1:0];
        stk_wdata      = {cur_node_reg, CNT_W'(pend_idx_reg) + CNT_W'(1), cur_best_reg};

        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                adj_we       = 1'b1;
                adj_waddr    = clr_cnt_reg;
                adj_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADJ_AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.func == pmeq_pkg::FUNC_LOAD)
                    begin
                        if (a_ok && b_ok)
                        begin
                            adj_we      = 1'b1;
                            adj_waddr   = {a_idx, b_idx};
                            adj_wdata   = w_in;
                            ld_row_next = b_idx;
                            ld_col_next = a_idx;
                            ld_w_next   = w_in;
                            state_next  = ST_WR2;
                        end
                    end
                    else if (a_ok && b_ok && (a_idx != b_idx))
                    begin
                        visited_next        = '0;
                        visited_next[a_idx] = 1'b1;
                        cur_node_next       = a_idx;
                        dst_next            = b_idx;
                        cur_best_next       = '0;
                        scan_i_next         = '0;
                        pend_vld_next       = 1'b0;
                        sp_next             = '0;
                        state_next          = ST_SCAN;
                    end
                    else
                    begin
                        res_found_next = 1'b0;
                        res_best_next  = '0;
                        state_next     = ST_RESP;
                    end
                end
            end
            ST_WR2:
            begin
                adj_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    pend_vld_next = 1'b0;
                    if (pend_idx_reg == dst_reg)
                    begin
                        res_found_next = 1'b1;
                        res_best_next  = cand;
                        state_next     = ST_RESP;
                    end
                    else
                    begin
                        // Descend: park the current frame, resume it later past this neighbor.
                        stk_we                     = 1'b1;
                        sp_next                    = sp_reg + CNT_W'(1);
                        cur_node_next              = pend_idx_reg;
                        cur_best_next              = cand;
                        scan_i_next                = '0;
                        visited_next[pend_idx_reg] = 1'b1;
                    end
                end
                else if (scan_end)
                begin
                    pend_vld_next = 1'b0;
                    if (sp_reg == '0)
                    begin
                        res_found_next = 1'b0;
                        res_best_next  = '0;
                        state_next     = ST_RESP;
                    end
                    else
                    begin
                        sp_next    = sp_reg - CNT_W'(1);
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    pend_vld_next = !visited_reg[scan_idx];
                    pend_idx_next = scan_idx;
                    scan_i_next   = scan_i_reg + CNT_W'(1);
                end
            end
            ST_POP:
            begin
                cur_node_next = stk_rdata_reg[STK_W-1 -: IDX_W];
                scan_i_next   = stk_rdata_reg[WEIGHT_BITS +: CNT_W];
                cur_best_next = stk_rdata_reg[WEIGHT_BITS-1:0];
                pend_vld_next = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_RESP:
            begin
                if (!out_vld_reg || !out_stall)
                begin
                    out_vld_next             = 1'b1;
                    out_data_next.max_weight = pmeq_pkg::WEIGHT_FIELD_W'(res_best_reg);
                    out_data_next.found      = res_found_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pend_vld_reg <= 1'b0;
            sp_reg       <= '0;
            visited_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pend_vld_reg <= pend_vld_next;
            sp_reg       <= sp_next;
            visited_reg  <= visited_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg       <= dst_next;
        cur_node_reg  <= cur_node_next;
        cur_best_reg  <= cur_best_next;
        scan_i_reg    <= scan_i_next;
        pend_idx_reg  <= pend_idx_next;
        res_found_reg <= res_found_next;
        res_best_reg  <= res_best_next;
        ld_row_reg    <= ld_row_next;
        ld_col_reg    <= ld_col_next;
        ld_w_reg      <= ld_w_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    // Each node enters the stack at most once per query.
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= CNT_W'(NODES))
        else $error("search stack pointer beyond node count");

    // A pending neighbor read only exists while scanning.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_CLEAR || state_reg == ST_WR2)
        |-> !pend_vld_reg)
        else $error("pending adjacency read outside a search");

    // A found path crosses at least one nonzero edge; no path reports zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_data_reg.found == (out_data_reg.max_weight != '0)))
        else $error("result weight disagrees with found flag");

    // A pop always resumes a frame that was pushed before.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> ($past(sp_reg) != '0))
        else $error("pop from an empty search stack");

endmodule

// ===== verif/pmeq_checker.sv =====
// Checker for the path maximum edge query block: edge store model, search prediction, compare.
module pmeq_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  pmeq_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  pmeq_pkg::out_t out_data,
    output int             fail_count,
    output int             answers_pending,
    output int             queries_seen,
    output int             paths_found
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N  = pmeq_pkg::NODES_DEF;
    localparam int WW = pmeq_pkg::WEIGHT_FIELD_W;

    logic [WW-1:0]  edge_weight [N][N];
    pmeq_pkg::out_t answer_queue [$];

    // Depth-first search with neighbors tried in ascending order.
    function automatic pmeq_pkg::out_t search_path(int src, int dst);
        bit             seen [N];
        int             node_stk [N];
        int             next_stk [N];
        logic [WW-1:0]  best_stk [N];
        int             depth;
        int             i;
        logic [WW-1:0]  w;
        logic [WW-1:0]  cand;
        pmeq_pkg::out_t r;
        r = '0;
        if (src == dst) return r;
        foreach (seen[k]) seen[k] = 1'b0;
        seen[src] = 1'b1;
        node_stk[0] = src;
        next_stk[0] = 0;
        best_stk[0] = '0;
        depth = 1;
        while (depth > 0) begin
            i = next_stk[depth-1];
            while (i < N && (seen[i] || edge_weight[node_stk[depth-1]][i] == 0)) i++;
            if (i >= N) begin
                depth--;
                continue;
            end
            next_stk[depth-1] = i + 1;
            w = edge_weight[node_stk[depth-1]][i];
            cand = (w > best_stk[depth-1]) ? w : best_stk[depth-1];
            if (i == dst) begin
                r.max_weight = cand;
                r.found = 1'b1;
                return r;
            end
            seen[i] = 1'b1;
            node_stk[depth] = i;
            next_stk[depth] = 0;
            best_stk[depth] = cand;
            depth++;
        end
        return r;
    endfunction

    assign answers_pending = answer_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        pmeq_pkg::out_t want;
        if (!rst_n)
        begin
            foreach (edge_weight[a, b]) edge_weight[a][b] = '0;
            answer_queue.delete();
            fail_count   <= 0;
            queries_seen <= 0;
            paths_found  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (in_data.func == pmeq_pkg::FUNC_LOAD)
                begin
                    edge_weight[in_data.node_a][in_data.node_b] = in_data.weight;
                    edge_weight[in_data.node_b][in_data.node_a] = in_data.weight;
                end
                else
                begin
                    want = search_path(in_data.node_a, in_data.node_b);
                    answer_queue = {answer_queue, want};
                    queries_seen <= queries_seen + 1;
                    if (want.found) paths_found <= paths_found + 1;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (answer_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result transfer %p", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (want.max_weight !== out_data.max_weight || want.found !== out_data.found)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: expected max_weight %0d found %0b, got %0d %0b",
                                     want.max_weight, want.found,
                                     out_data.max_weight, out_data.found);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/tb_top.sv =====
// Testbench top of the path maximum edge query block: stimulus, idling and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 200000;
    localparam int HOLD_CYCLES = 600;
    localparam int NW          = pmeq_pkg::NODE_FIELD_W;
    localparam int WW          = pmeq_pkg::WEIGHT_FIELD_W;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    pmeq_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    pmeq_pkg::out_t out_data;

    int fail_count;
    int answers_pending;
    int queries_seen;
    int paths_found;

    // Idle control: a calm phase has no idling. A hold-off request makes the
    // receiver stall for a counted stretch so the block backs up into its input.
    bit calm;
    bit hold_req;
    bit hold_done;
    int quiet_cycles;

    path_max_edge_query dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    pmeq_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .fail_count     (fail_count),
        .answers_pending(answers_pending),
        .queries_seen   (queries_seen),
        .paths_found    (paths_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver side: random stalls unless calm; one long counted hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 22);
        end
    end

    // Watchdog: the run ends if no transfer happens on either channel for too long.
    // The clearing pass after reset is far shorter than the limit.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else if (++quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", answers_pending);
                $display("path_max_edge_query test failed");
                $finish;
            end
        end
    end

    // Offers one transfer, with a random idle gap first unless calm, and
    // waits until the block accepts it.
    task automatic send_item(logic fn, int a, int b, logic [WW-1:0] w);
        pmeq_pkg::in_t item;
        item.func   = fn;
        item.node_a = a[NW-1:0];
        item.node_b = b[NW-1:0];
        item.weight = w;
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic load_edge(int a, int b, logic [WW-1:0] w);
        send_item(pmeq_pkg::FUNC_LOAD, a, b, w);
    endtask

    task automatic ask_path(int src, int dst);
        send_item(pmeq_pkg::FUNC_QUERY, src, dst, WW'($urandom));
    endtask

    // Random weight, sometimes at the extremes.
    function automatic logic [WW-1:0] pick_weight();
        case ($urandom_range(5))
            0: return '1;
            1: return WW'(1);
            default: return WW'($urandom_range(1, 1000));
        endcase
    endfunction

    initial
    begin
        int order [64];
        int tree_size;
        int idx;
        int tmp;
        in_valid = 1'b0;
        in_data  = '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty store, self queries, extremes, self loop, removal.
        ask_path(0, 63);
        ask_path(5, 5);
        load_edge(0, 63, '1);
        ask_path(0, 63);
        ask_path(63, 0);
        load_edge(63, 1, WW'(1));
        ask_path(0, 1);
        load_edge(1, 1, WW'(99));
        ask_path(1, 0);
        load_edge(2, 3, WW'(7));
        ask_path(0, 3);
        load_edge(3, 1, WW'(12));
        ask_path(2, 0);
        ask_path(0, 2);
        load_edge(0, 63, '0);
        ask_path(0, 2);
        ask_path(63, 2);
        load_edge(62, 61, WW'(31'h2AAA_AAAA));
        ask_path(61, 62);
        load_edge(62, 61, WW'(31'h5555_5555));
        ask_path(62, 61);

        // Random part: build random trees on shuffled node sets, query them,
        // mixed with stray loads, removals and unrelated queries.
        repeat (6)
        begin
            foreach (order[k]) order[k] = k;
            for (int k = 63; k > 0; k--)
            begin
                idx = $urandom_range(k);
                tmp = order[k];
                order[k] = order[idx];
                order[idx] = tmp;
            end
            tree_size = $urandom_range(4, 12);
            for (int k = 1; k < tree_size; k++)
                load_edge(order[k], order[$urandom_range(k - 1)], pick_weight());
            repeat (8)
                ask_path(order[$urandom_range(tree_size - 1)],
                         order[$urandom_range(tree_size - 1)]);
            if ($urandom_range(1))
                load_edge($urandom_range(63), $urandom_range(63), pick_weight());
            else
                load_edge(order[1], order[0], '0);
            ask_path($urandom_range(63), $urandom_range(63));
        end

        // Long stretch without any idling on either side.
        calm = 1'b1;
        repeat (20)
            ask_path($urandom_range(63), $urandom_range(63));
        calm = 1'b0;

        // Receiver holds off while queries keep coming, so the block backs up.
        hold_req = 1'b1;
        repeat (6)
            ask_path($urandom_range(63), $urandom_range(63));
        wait (hold_done);

        in_valid <= 1'b0;
        while (answers_pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d queries, %0d with a path, across random trees and hold-off.",
                 queries_seen, paths_found);
        if (fail_count == 0)
            $display("path_max_edge_query test passed");
        else
            $display("path_max_edge_query test failed");
        $finish;
    end
endmodule
